[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define DSR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define DSR_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define DSR_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/dsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared constants, codes and types of the data stack with rotate.
// ----------------------------------------------------------------------------
package dsr_pkg;

	localparam int unsigned DEPTH_DEF     = 32;
	localparam int unsigned WORD_BITS_DEF = 32;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned AMOUNT_W = 16;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned LEVEL_W  = 6;

	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_GET  = 2'd2,
		KIND_ROT  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_END   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_FIN,
		S_DIV,
		S_PHASE,
		S_RA,
		S_RB,
		S_WA,
		S_WB
	} state_t;

endpackage

[rtl/dsr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr channels
// Request and response channels of the stack, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dsr_cmd_if;
	logic                                 valid;
	logic                                 ready;
	dsr_pkg::kind_t                       kind;
	logic        [dsr_pkg::VALUE_W-1:0]   value;
	logic        [dsr_pkg::COUNT_W-1:0]   count;
	logic signed [dsr_pkg::AMOUNT_W-1:0]  amount;

	modport source(output valid, kind, value, count, amount, input ready);
	modport sink(input valid, kind, value, count, amount, output ready);
endinterface

interface dsr_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [dsr_pkg::DATA_W-1:0]     data;
	dsr_pkg::status_t               status;
	logic [dsr_pkg::LEVEL_W-1:0]    level;

	modport source(output valid, data, status, level, input ready);
	modport sink(input valid, data, status, level, output ready);
endinterface

[rtl/dsr_urem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_urem
// Restoring unsigned remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module dsr_urem #(
	parameter int unsigned NUM_W = dsr_pkg::AMOUNT_W,
	parameter int unsigned DEN_W = $clog2(dsr_pkg::DEPTH_DEF + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [DEN_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	// remainder stays below the divisor, so the trial value stays below twice it
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[rtl/data_stack_with_rotate.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// data_stack_with_rotate
// Word stack with a cursor and in-place rotation of a run above the cursor.
// ----------------------------------------------------------------------------
// After reset the block sweeps the word memory to zero, one word per cycle,
// and takes no request until the sweep is done. Push, pop and get each cost
// at most one memory access and respond from the FIN state. Rotate first
// reduces the signed distance modulo the clipped run length in a bit-serial
// remainder unit, then rotates in place as three reversals over the single
// write / single read memory, each word swap passing the RA, RB, WA and WB
// states. Zero-length runs and a cursor at the end skip the remainder unit;
// a distance that reduces to zero ends after the remainder with no reversal.
// A finished response waits in an output register,
// so a new request is taken while the previous one is held.
module data_stack_with_rotate #(
	parameter int unsigned DEPTH     = dsr_pkg::DEPTH_DEF,
	parameter int unsigned WORD_BITS = dsr_pkg::WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	dsr_cmd_if.sink          cmd,
	dsr_rsp_if.source        rsp
);

	localparam int unsigned AW      = $clog2(DEPTH);
	localparam int unsigned CW      = $clog2(DEPTH + 1);
	localparam int unsigned COUNT_W = dsr_pkg::COUNT_W;
	localparam int unsigned MAG_W   = dsr_pkg::AMOUNT_W;
	localparam int unsigned DATA_W  = dsr_pkg::DATA_W;
	localparam int unsigned LEVEL_W = dsr_pkg::LEVEL_W;
	localparam int unsigned CMPW    = (COUNT_W > CW) ? COUNT_W : CW;

	// word memory
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;

	dsr_pkg::state_t      state_q;
	dsr_pkg::state_t      state_d;
	logic [CW-1:0]        cursor_q;
	dsr_pkg::status_t     res_status_q;
	logic                 res_rd_q;
	logic [CW-1:0]        len_q;
	logic                 neg_q;
	logic [CW-1:0]        d_q;
	logic [1:0]           ph_q;
	logic [AW-1:0]        lo_q;
	logic [AW-1:0]        hi_q;
	logic [WORD_BITS-1:0] tmp_q;
	logic [AW-1:0]        clr_q;

	logic                 rsp_vld_q;
	logic [DATA_W-1:0]    rsp_data_q;
	dsr_pkg::status_t     rsp_status_q;
	logic [LEVEL_W-1:0]   rsp_level_q;

	logic                 acc;
	logic                 full;
	logic                 empty;
	logic [CW-1:0]        avail;
	logic [CW-1:0]        cur_m1;
	logic [CW-1:0]        len_d;
	logic                 amt_neg;
	logic [MAG_W-1:0]     amt_mag;
	logic                 div_start;
	logic                 div_done;
	logic [CW-1:0]        div_rem;
	logic [CW-1:0]        cd;
	logic [CW-1:0]        cl;
	logic [CW-1:0]        cd_m1;
	logic [CW-1:0]        cl_m1;
	logic                 rsp_load;
	logic                 rsp_free;
	logic                 swap_go;
	logic                 in_swap;
	logic                 mem_act;

	assign cmd.ready = (state_q == dsr_pkg::S_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign full      = (cursor_q == CW'(DEPTH));
	assign empty     = (cursor_q == '0);
	assign avail     = CW'(DEPTH) - cursor_q;
	assign cur_m1    = cursor_q - CW'(1);
	assign len_d     = (CMPW'(cmd.count) > CMPW'(avail)) ? avail : CW'(cmd.count);
	assign amt_neg   = cmd.amount[MAG_W-1];
	assign amt_mag   = amt_neg ? (~$unsigned(cmd.amount) + MAG_W'(1)) : $unsigned(cmd.amount);
	assign rsp_free  = !rsp_vld_q || rsp.ready;
	assign swap_go   = (lo_q < hi_q);
	assign in_swap   = (state_q == dsr_pkg::S_RB) || (state_q == dsr_pkg::S_WA) ||
	                   (state_q == dsr_pkg::S_WB);
	assign mem_act   = mem_we || mem_re;

	// reversal bounds: [c, c+d-1], then [c+d, c+len-1], then [c, c+len-1]
	assign cd    = cursor_q + d_q;
	assign cl    = cursor_q + len_q;
	assign cd_m1 = cd - CW'(1);
	assign cl_m1 = cl - CW'(1);

	dsr_urem #(
		.NUM_W(MAG_W),
		.DEN_W(CW)
	) u_urem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (amt_mag),
		.den   (len_d),
		.done  (div_done),
		.rem   (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dsr_pkg::S_CLR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = dsr_pkg::S_IDLE;
			end
			dsr_pkg::S_IDLE: begin
				if (acc) begin
					if (cmd.kind == dsr_pkg::KIND_ROT && !full && len_d != '0)
						state_d = dsr_pkg::S_DIV;
					else
						state_d = dsr_pkg::S_FIN;
				end
			end
			dsr_pkg::S_DIV: begin
				if (div_done) state_d = (div_rem == '0) ? dsr_pkg::S_FIN : dsr_pkg::S_PHASE;
			end
			dsr_pkg::S_PHASE: state_d = dsr_pkg::S_RA;
			dsr_pkg::S_RA: begin
				if (swap_go)             state_d = dsr_pkg::S_RB;
				else if (ph_q == 2'd2)   state_d = dsr_pkg::S_FIN;
				else                     state_d = dsr_pkg::S_PHASE;
			end
			dsr_pkg::S_RB: state_d = dsr_pkg::S_WA;
			dsr_pkg::S_WA: state_d = dsr_pkg::S_WB;
			dsr_pkg::S_WB: state_d = dsr_pkg::S_RA;
			dsr_pkg::S_FIN: begin
				if (rsp_free) state_d = dsr_pkg::S_IDLE;
			end
			default: state_d = dsr_pkg::S_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lo_q;
		mem_wdata = rdata_q;
		mem_re    = 1'b0;
		mem_raddr = lo_q;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			dsr_pkg::S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			dsr_pkg::S_IDLE: begin
				if (acc) begin
					case (cmd.kind)
						dsr_pkg::KIND_PUSH: begin
							mem_we    = !full;
							mem_waddr = cursor_q[AW-1:0];
							mem_wdata = WORD_BITS'(cmd.value);
						end
						dsr_pkg::KIND_POP: begin
							mem_re    = !empty;
							mem_raddr = cur_m1[AW-1:0];
						end
						dsr_pkg::KIND_GET: begin
							mem_re    = !full;
							mem_raddr = cursor_q[AW-1:0];
						end
						default: begin
							div_start = !full && len_d != '0;
						end
					endcase
				end
			end
			dsr_pkg::S_RA: begin
				mem_re    = swap_go;
				mem_raddr = lo_q;
			end
			dsr_pkg::S_RB: begin
				mem_re    = 1'b1;
				mem_raddr = hi_q;
			end
			dsr_pkg::S_WA: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = rdata_q;
			end
			dsr_pkg::S_WB: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = tmp_q;
			end
			dsr_pkg::S_FIN: begin
				rsp_load = rsp_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dsr_pkg::S_CLR;
			cursor_q  <= '0;
			clr_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dsr_pkg::S_CLR) clr_q <= clr_q + AW'(1);
			if (acc) begin
				case (cmd.kind)
					dsr_pkg::KIND_PUSH: if (!full)  cursor_q <= cursor_q + CW'(1);
					dsr_pkg::KIND_POP:  if (!empty) cursor_q <= cur_m1;
					dsr_pkg::KIND_GET:  if (!full)  cursor_q <= cursor_q + CW'(1);
					default: ;
				endcase
			end
			if (rsp_load)       rsp_vld_q <= 1'b1;
			else if (rsp.ready) rsp_vld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			len_q <= len_d;
			neg_q <= amt_neg;
			case (cmd.kind)
				dsr_pkg::KIND_PUSH: begin
					res_rd_q     <= 1'b0;
					res_status_q <= full ? dsr_pkg::ST_FULL : dsr_pkg::ST_OK;
				end
				dsr_pkg::KIND_POP: begin
					res_rd_q     <= !empty;
					res_status_q <= empty ? dsr_pkg::ST_EMPTY : dsr_pkg::ST_OK;
				end
				default: begin
					res_rd_q     <= (cmd.kind == dsr_pkg::KIND_GET) && !full;
					res_status_q <= full ? dsr_pkg::ST_END : dsr_pkg::ST_OK;
				end
			endcase
		end
		if (state_q == dsr_pkg::S_DIV && div_done) begin
			// right by amt is left by len - amt; a negative distance flips it
			d_q  <= neg_q ? div_rem : (len_q - div_rem);
			ph_q <= 2'd0;
		end
		if (state_q == dsr_pkg::S_PHASE) begin
			case (ph_q)
				2'd0: begin
					lo_q <= cursor_q[AW-1:0];
					hi_q <= cd_m1[AW-1:0];
				end
				2'd1: begin
					lo_q <= cd[AW-1:0];
					hi_q <= cl_m1[AW-1:0];
				end
				default: begin
					lo_q <= cursor_q[AW-1:0];
					hi_q <= cl_m1[AW-1:0];
				end
			endcase
		end
		if (state_q == dsr_pkg::S_RA && !swap_go) ph_q <= ph_q + 2'd1;
		if (state_q == dsr_pkg::S_RB) tmp_q <= rdata_q;
		if (state_q == dsr_pkg::S_WB) begin
			lo_q <= lo_q + AW'(1);
			hi_q <= hi_q - AW'(1);
		end
		if (rsp_load) begin
			rsp_data_q   <= res_rd_q ? DATA_W'(rdata_q) : '0;
			rsp_status_q <= res_status_q;
			rsp_level_q  <= LEVEL_W'(cursor_q);
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.status = rsp_status_q;
	assign rsp.level  = rsp_level_q;

	`DSR_ASSERT(a_cursor_range, clk, arst_n, cursor_q <= CW'(DEPTH), "cursor beyond depth")
	`DSR_ASSERT(a_cursor_hold, clk, arst_n, !acc |=> $stable(cursor_q), "cursor moved idle")
	`DSR_ASSERT(a_swap_order, clk, arst_n, in_swap |-> (lo_q < hi_q), "swap bounds crossed")
	`DSR_ASSERT(a_div_done, clk, arst_n, div_done |-> (state_q == dsr_pkg::S_DIV), "stray rem")
	`DSR_NEVER(a_fin_quiet, clk, arst_n, (state_q == dsr_pkg::S_FIN) && mem_act, "memory busy in FIN")

endmodule
